/* rtl/core/mads_pkg.sv */
// ----------------------------------------------------------------------------
// mads_pkg
// Shared types and constants for the median / absolute deviation sum core.
// ----------------------------------------------------------------------------
package mads_pkg;

  localparam int VALUE_W       = 32;
  localparam int SUM_W         = 42;
  localparam int COUNT_W       = 11;
  localparam int MAX_COUNT_DEF = 1024;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] median;
    logic [SUM_W-1:0]   abs_dev_sum;
    logic [COUNT_W-1:0] element_count;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/core/mads_cell.sv */
// ----------------------------------------------------------------------------
// mads_cell
// One slot of the sorted insertion chain: takes the new value, its left
// neighbor's value, or its right neighbor's value when the chain drains.
// ----------------------------------------------------------------------------
module mads_cell (
  input  logic                         clk,
  input  mads_pkg::cell_ctrl_t         ctrl,
  input  logic [mads_pkg::VALUE_W-1:0] ins_value,
  input  logic                         vacant,
  input  logic [mads_pkg::VALUE_W-1:0] prev_value,
  input  logic                         prev_gt,
  input  logic [mads_pkg::VALUE_W-1:0] next_value,
  output logic [mads_pkg::VALUE_W-1:0] held,
  output logic                         gt
);
  import mads_pkg::*;

  assign gt = vacant || (held > ins_value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= next_value;
    end else if (ctrl.insert) begin
      if (prev_gt) begin
        held <= prev_value;
      end else if (gt) begin
        held <= ins_value;
      end
    end
  end

endmodule

/* rtl/core/median_abs_deviation_sum_core.sv */
// ----------------------------------------------------------------------------
// median_abs_deviation_sum_core
// Lower median and sum of absolute deviations over a set of unsigned values,
// kept sorted in a chain of insertion cells and drained head first.
// ----------------------------------------------------------------------------
//  channel  | signals                          | payload
//  ---------+----------------------------------+----------------
//  item     | item_valid, item_ready, item     | mads_pkg::item_t
//  result   | result_valid, result_ready, result | mads_pkg::result_t
//
//  Load: one transaction per cycle, each value placed in sorted order; values
//  beyond MAX_COUNT are dropped and set overflow. After the transaction marked
//  last the chain drains through its head, then S_MUL and S_SUM finish the sum.
//  item_ready is low from the last transaction until the result is registered.
//  A stalled result holds while the next set loads; the next result then
//  waits in the final step, input held off, until the stalled one leaves.
//  Reset clears the fill count, flags and state; cell contents need none.
// ----------------------------------------------------------------------------
module median_abs_deviation_sum_core #(
  parameter int MAX_COUNT = mads_pkg::MAX_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mads_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output mads_pkg::result_t   result
);
  import mads_pkg::*;

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int PW = VALUE_W + CW;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_DRAIN = 4'b0010,
    S_MUL   = 4'b0100,
    S_SUM   = 4'b1000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic               dropped;
  logic [CW-1:0]      drain_idx;
  logic [VALUE_W-1:0] median_r;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   prod;

  logic [CW:0]        count_p1;
  logic [CW-1:0]      rank_m1;
  logic [PW-1:0]      prod_full;
  logic               accept;
  logic               full;
  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] head;

  logic [VALUE_W-1:0] cell_q  [MAX_COUNT];
  logic               cell_gt [MAX_COUNT];

  assign item_ready = (state == S_LOAD);
  assign accept     = item_valid && item_ready;
  assign full       = (count == CW'(MAX_COUNT));
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state == S_DRAIN);

  assign count_p1  = {1'b0, count} + (CW+1)'(1);
  assign rank_m1   = count_p1[CW:1] - CW'(1);
  assign prod_full = PW'(median_r) * PW'(rank_m1);
  assign head      = cell_q[0];

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_v;
    logic               prev_g;
    logic [VALUE_W-1:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = item.value;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_v = cell_q[i-1];
      assign prev_g = cell_gt[i-1];
    end

    if (i == MAX_COUNT - 1) begin : g_tail
      assign next_v = cell_q[i];
    end else begin : g_link
      assign next_v = cell_q[i+1];
    end

    mads_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (item.value),
      .vacant     (CW'(i) >= count),
      .prev_value (prev_v),
      .prev_gt    (prev_g),
      .next_value (next_v),
      .held       (cell_q[i]),
      .gt         (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      dropped      <= 1'b0;
      drain_idx    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_SUM)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (item.last) begin
              state     <= S_DRAIN;
              drain_idx <= '0;
            end
          end
        end
        S_DRAIN: begin
          drain_idx <= drain_idx + CW'(1);
          if (drain_idx == count - CW'(1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            count        <= '0;
            dropped      <= 1'b0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        acc <= '0;
      end
      S_DRAIN: begin
        if (drain_idx < rank_m1) begin
          acc <= acc - SUM_W'(head);
        end else if (drain_idx == rank_m1) begin
          median_r <= head;
        end else begin
          acc <= acc + SUM_W'(head - median_r);
        end
      end
      S_MUL: begin
        prod <= SUM_W'(prod_full);
      end
      S_SUM: begin
        if (!result_valid || result_ready) begin
          result.median        <= median_r;
          result.abs_dev_sum   <= acc + prod;
          result.element_count <= COUNT_W'(count);
          result.overflow      <= dropped;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_COUNT))
    else $error("fill count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> (count != '0) && (drain_idx < count))
    else $error("drain outside the stored range");

  a_drain_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) && (drain_idx > rank_m1) |-> (head >= median_r))
    else $error("chain head below median after median drained");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_SUM))
    else $error("result raised outside the final step");

endmodule
